// ===== sv/ers_pkg.sv =====
// shared types, constants and microprogram for the elevator request scan block
package ers_pkg;

  localparam int ERS_QUEUE_DEPTH = 16;
  localparam int ERS_FLOOR_BITS  = 6;
  localparam int UC_PC_W         = 2;

  // datapath operation selected by the control word
  typedef enum logic [3:0] {
    UOP_NOP    = 4'b0001,
    UOP_ACCEPT = 4'b0010,
    UOP_SORT   = 4'b0100,
    UOP_WALK   = 4'b1000
  } uop_t;

  // jump condition, the step holds while it is false
  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_START  = 2'd1,
    COND_SORTED = 2'd2,
    COND_WALKED = 2'd3
  } cond_t;

  typedef logic [UC_PC_W-1:0] uc_pc_t;

  typedef struct packed {
    uop_t   op;
    cond_t  cond;
    uc_pc_t target;
  } uc_word_t;

  typedef struct packed {
    logic start;
    logic sorted;
    logic walked;
  } uc_stat_t;

  localparam uc_pc_t UC_ACCEPT = 2'd0;
  localparam uc_pc_t UC_SORT   = 2'd1;
  localparam uc_pc_t UC_WALK   = 2'd2;

  function automatic uc_word_t uc_rom(input uc_pc_t pc);
    uc_word_t w;
    case (pc)
      UC_ACCEPT: w = '{op: UOP_ACCEPT, cond: COND_START,  target: UC_SORT};
      UC_SORT:   w = '{op: UOP_SORT,   cond: COND_SORTED, target: UC_WALK};
      UC_WALK:   w = '{op: UOP_WALK,   cond: COND_WALKED, target: UC_ACCEPT};
      default:   w = '{op: UOP_NOP,    cond: COND_ALWAYS, target: UC_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/ers_in_if.sv =====
// request channel: store or execute command with a floor number
interface ers_in_if
  import ers_pkg::*;
#(
  parameter int FLOOR_BITS = ERS_FLOOR_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [FLOOR_BITS-1:0] floor;

  modport source (output valid, output func, output floor, input ready);
  modport sink   (input valid, input func, input floor, output ready);
endinterface

// ===== sv/ers_out_if.sv =====
// service channel: served floor with end of scan flag
interface ers_out_if
  import ers_pkg::*;
#(
  parameter int FLOOR_BITS = ERS_FLOOR_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [FLOOR_BITS-1:0] served_floor;
  logic                  last;

  modport source (output valid, output served_floor, output last, input ready);
  modport sink   (input valid, input served_floor, input last, output ready);
endinterface

// ===== sv/elevator_request_scan_order.sv =====
// top level of the elevator request scan block
// A store appends its floor to the request queue (dropped when the queue is full) and
// gives no result; so does an execute on an empty queue or whose front entry is the car
// floor. Any other execute on a queue of N requests takes its direction from the front
// entry, then runs N odd-even compare-swap passes over the queue cells and N walk steps
// that rotate the queue one place each and offer the front entry when it is past the car
// floor in the scan direction; a stalled result side holds the walk. The sort passes and
// the walk run from a three-step microprogram, so one item is in work at a time; the next
// item is taken once the walk has handed over its final floor, which may still sit in the
// output register as the next item arrives. The queue needs no clearing after reset. The
// user must write current_floor via cfg_we and cfg_wdata only while idle; not enforced.
module elevator_request_scan_order
  import ers_pkg::*;
#(
  parameter int QUEUE_DEPTH = ERS_QUEUE_DEPTH,
  parameter int FLOOR_BITS  = ERS_FLOOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ers_in_if.sink                in_ch,
  ers_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [FLOOR_BITS-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // floor the car stands at
  logic [FLOOR_BITS-1:0] cur_floor_r, cur_floor_nxt;

  // control word out of the sequencer, jump conditions back from the datapath
  uc_word_t         ctrl;
  uc_stat_t         stat;
  logic [CNT_W-1:0] req_count;

  assign cur_floor_nxt = cfg_we ? cfg_wdata : cur_floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_floor_r <= '0;
    end else begin
      cur_floor_r <= cur_floor_nxt;
    end
  end

  // step counter and control store
  ers_useq u_useq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  // queue cells, sorter, walk and output register
  ers_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .FLOOR_BITS (FLOOR_BITS)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cur_floor(cur_floor_r),
    .stat     (stat),
    .req_count(req_count),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // a store with room grows the queue by exactly one
  a_store_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !in_ch.func && (req_count != CNT_W'(QUEUE_DEPTH))
    |=> req_count == $past(req_count) + CNT_W'(1))
    else $error("store did not grow the queue by one");

  // a store on a full queue is dropped
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !in_ch.func && (req_count == CNT_W'(QUEUE_DEPTH))
    |=> req_count == CNT_W'(QUEUE_DEPTH))
    else $error("store on a full queue changed the count");

  // the final walk step always serves a floor and flags it as last
  a_walk_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    stat.walked |=> out_ch.valid && out_ch.last)
    else $error("end of walk without a last item");

  // the end of the walk returns the program to accepting items
  a_walk_end_accept: assert property (@(posedge clk) disable iff (!rst_n)
    stat.walked |=> ctrl.op == UOP_ACCEPT)
    else $error("sequencer did not return to accept after the walk");

endmodule

// ===== sv/ers_useq.sv =====
// microcode sequencer: step counter, control store and conditional jumps
module ers_useq
  import ers_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  uc_stat_t stat,
  output uc_word_t ctrl
);

  uc_pc_t pc_r;
  uc_pc_t pc_nxt;
  logic   jump;

  assign ctrl = uc_rom(pc_r);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS: jump = 1'b1;
      COND_START:  jump = stat.start;
      COND_SORTED: jump = stat.sorted;
      COND_WALKED: jump = stat.walked;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UC_ACCEPT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== sv/ers_queue.sv =====
// request queue datapath: append, odd-even sort passes, rotating walk, output register
module ers_queue
  import ers_pkg::*;
#(
  parameter int QUEUE_DEPTH = ERS_QUEUE_DEPTH,
  parameter int FLOOR_BITS  = ERS_FLOOR_BITS,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  uc_word_t              ctrl,
  input  logic [FLOOR_BITS-1:0] cur_floor,
  output uc_stat_t              stat,
  output logic [CNT_W-1:0]      req_count,
  ers_in_if.sink                in_ch,
  ers_out_if.source             out_ch
);

  logic [FLOOR_BITS-1:0] ent_r   [QUEUE_DEPTH];
  logic [FLOOR_BITS-1:0] ent_nxt [QUEUE_DEPTH];
  logic [FLOOR_BITS-1:0] nb_hi   [QUEUE_DEPTH];
  logic [FLOOR_BITS-1:0] nb_lo   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] swp;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  dir_up_r, dir_up_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FLOOR_BITS-1:0] served_r, served_nxt;
  logic                  last_r, last_nxt;

  logic             acc;
  logic             store;
  logic             full;
  logic             cnt_last;
  logic             out_free;
  logic             take;
  logic             walk_adv;
  logic [CNT_W-1:0] top_idx;

  assign in_ch.ready         = (ctrl.op == UOP_ACCEPT);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.served_floor = served_r;
  assign out_ch.last         = last_r;
  assign req_count           = count_r;

  assign acc      = in_ch.valid & in_ch.ready;
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign store    = acc & ~in_ch.func & ~full;
  assign top_idx  = count_r - CNT_W'(1);
  assign cnt_last = (CNT_W'(cnt_r) == top_idx);
  assign out_free = ~out_valid_r | out_ch.ready;
  assign take     = dir_up_r ? (ent_r[0] > cur_floor) : (ent_r[0] < cur_floor);
  assign walk_adv = (ctrl.op == UOP_WALK) & out_free;

  assign stat.start  = acc & in_ch.func & (count_r != '0) & (ent_r[0] != cur_floor);
  assign stat.sorted = (ctrl.op == UOP_SORT) & cnt_last;
  assign stat.walked = walk_adv & cnt_last;

  // neighbours and compare-swap flags of each cell, pair parity follows the pass count
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      nb_hi[i] = ent_r[(i == QUEUE_DEPTH - 1) ? i : i + 1];
      nb_lo[i] = ent_r[(i == 0) ? 0 : i - 1];
      swp[i]   = (1'(i) == cnt_r[0]) && (CNT_W'(i + 1) < count_r) &&
                 (dir_up_r ? (ent_r[i] > nb_hi[i]) : (ent_r[i] < nb_hi[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
      case (ctrl.op)
        UOP_ACCEPT: begin
          if (store && (count_r == CNT_W'(i))) begin
            ent_nxt[i] = in_ch.floor;
          end
        end
        UOP_SORT: begin
          if (swp[i]) begin
            ent_nxt[i] = nb_hi[i];
          end else if ((i > 0) && swp[(i == 0) ? 0 : i - 1]) begin
            ent_nxt[i] = nb_lo[i];
          end
        end
        UOP_WALK: begin
          // rotate the valid part left by one, front goes to the back
          if (walk_adv) begin
            if (CNT_W'(i) == top_idx) begin
              ent_nxt[i] = ent_r[0];
            end else if (CNT_W'(i) < top_idx) begin
              ent_nxt[i] = nb_hi[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_nxt     = count_r;
    cnt_nxt       = cnt_r;
    dir_up_nxt    = dir_up_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    served_nxt    = served_r;
    last_nxt      = last_r;
    case (ctrl.op)
      UOP_ACCEPT: begin
        cnt_nxt = '0;
        if (store) begin
          count_nxt = count_r + CNT_W'(1);
        end
        if (stat.start) begin
          dir_up_nxt = (ent_r[0] > cur_floor);
        end
      end
      UOP_SORT: begin
        cnt_nxt = cnt_last ? '0 : cnt_r + IDX_W'(1);
      end
      UOP_WALK: begin
        if (walk_adv) begin
          cnt_nxt = cnt_last ? '0 : cnt_r + IDX_W'(1);
          if (take) begin
            out_valid_nxt = 1'b1;
            served_nxt    = ent_r[0];
            last_nxt      = cnt_last;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cnt_r       <= '0;
      dir_up_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      dir_up_r    <= dir_up_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    served_r <= served_nxt;
    last_r   <= last_nxt;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the elevator request scan block
`timescale 1ns / 1ps

typedef logic [ers_pkg::ERS_FLOOR_BITS-1:0] floor_t;

typedef enum logic {
  FUNC_STORE   = 1'b0,
  FUNC_EXECUTE = 1'b1
} request_func_t;

typedef struct packed {
  floor_t served_floor;
  logic   last;
} stop_t;

// mirrors the request list and car position, holds the floors still to be served
class scan_scoreboard;
  floor_t      request_list[ers_pkg::ERS_QUEUE_DEPTH];
  int unsigned list_len;
  floor_t      car_floor;
  stop_t       awaited_stops[$];
  int unsigned mismatches;
  int unsigned stops_checked;
  int unsigned scans;
  int unsigned stores;
  int unsigned dropped;

  function new();
    list_len      = 0;
    car_floor     = '0;
    mismatches    = 0;
    stops_checked = 0;
    scans         = 0;
    stores        = 0;
    dropped       = 0;
  endfunction

  function void set_car_floor(floor_t v);
    car_floor = v;
  endfunction

  function int pending();
    return awaited_stops.size();
  endfunction

  // stable insertion sort, the list keeps its new order
  function void order_list(bit upward);
    int     i;
    int     j;
    floor_t v;
    for (i = 1; i < list_len; i++) begin
      v = request_list[i];
      j = i;
      while (j > 0 && (upward ? request_list[j-1] > v : request_list[j-1] < v)) begin
        request_list[j] = request_list[j-1];
        j--;
      end
      request_list[j] = v;
    end
  endfunction

  function void note_request(request_func_t func, floor_t fl);
    bit    upward;
    stop_t s;
    int    i;
    int    first;
    if (func == FUNC_STORE) begin
      stores++;
      if (list_len < ers_pkg::ERS_QUEUE_DEPTH) begin
        request_list[list_len] = fl;
        list_len++;
      end else begin
        dropped++;
      end
      return;
    end
    scans++;
    if (list_len == 0 || request_list[0] == car_floor) return;
    upward = request_list[0] > car_floor;
    order_list(upward);
    first = awaited_stops.size();
    for (i = 0; i < list_len; i++) begin
      if (upward ? request_list[i] > car_floor : request_list[i] < car_floor) begin
        s.served_floor = request_list[i];
        s.last         = 1'b0;
        awaited_stops  = {awaited_stops, s};
      end
    end
    if (awaited_stops.size() > first) begin
      s      = awaited_stops[awaited_stops.size() - 1];
      s.last = 1'b1;
      awaited_stops[awaited_stops.size() - 1] = s;
    end
  endfunction

  function void check_stop(floor_t served, logic last_flag);
    stop_t e;
    if (awaited_stops.size() == 0) begin
      $display("%0t: unexpected served floor %0d last %0b, expected nothing",
               $time, served, last_flag);
      mismatches++;
      return;
    end
    e = awaited_stops.pop_front();
    stops_checked++;
    if (served !== e.served_floor) begin
      $display("%0t: served_floor mismatch, expected %0d, actual %0d",
               $time, e.served_floor, served);
      mismatches++;
    end
    if (last_flag !== e.last) begin
      $display("%0t: last mismatch on floor %0d, expected %0b, actual %0b",
               $time, e.served_floor, e.last, last_flag);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  import ers_pkg::*;

  // one execute sorts and walks the whole list, plus margin
  localparam int SETTLE_CYCLES = 2 * ERS_QUEUE_DEPTH + 8;
  // long receiver hold-off to back the block up into its input
  localparam int HOLD_CYCLES   = 300;
  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT   = 3000;
  localparam int ITEM_TARGET   = 280;
  localparam int QUIET_FROM    = 230;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  floor_t cfg_wdata;

  ers_in_if  in_bus ();
  ers_out_if out_bus ();

  scan_scoreboard sb;

  bit no_idle       = 1'b0;   // set for the closing stretch of the run
  bit hold_off_req  = 1'b0;   // asks the result side for one long hold-off
  int unsigned positions = 0;
  int unsigned quiet_cycles = 0;

  elevator_request_scan_order uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one item, optionally after an idle burst, and hold it until taken;
  // valid stays high between back-to-back items so it is never toggled in one step
  task automatic send_request(input request_func_t f, input floor_t fl);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func  <= f;
    in_bus.floor <= fl;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.note_request(f, fl);
  endtask

  // stop offering, let every expected floor come out, then wait
  // SETTLE_CYCLES before going on
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // new car position, only ever written with the block idle
  task automatic move_car(input floor_t v);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_car_floor(v);
    positions++;
  endtask

  // result side: random stall bursts, one long hold-off on request,
  // always ready once the closing stretch begins
  initial begin : result_sink
    forever begin
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // every served floor is checked against the oldest one expected
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      sb.check_stop(out_bus.served_floor, out_bus.last);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, giving up", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int          phase;
    int          n;
    floor_t      car;
    counted = 0;
    phase   = 0;
    sb      = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_bus.valid <= 1'b0;
    in_bus.func  <= FUNC_STORE;
    in_bus.floor <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, duplicates, both scan directions, equal front
    move_car(6'd0);
    send_request(FUNC_EXECUTE, 6'd0);      // empty list serves nothing
    send_request(FUNC_STORE, 6'd63);
    send_request(FUNC_STORE, 6'd5);
    send_request(FUNC_STORE, 6'd5);        // duplicate request kept
    send_request(FUNC_STORE, 6'd1);
    send_request(FUNC_EXECUTE, 6'd63);     // front above, upward scan
    move_car(6'd1);
    send_request(FUNC_EXECUTE, 6'd0);      // front equals car floor
    move_car(6'd63);
    send_request(FUNC_EXECUTE, 6'd63);     // front below, downward scan
    // fill the list, then two stores that must be dropped
    send_request(FUNC_STORE, 6'd2);
    send_request(FUNC_STORE, 6'd4);
    send_request(FUNC_STORE, 6'd8);
    send_request(FUNC_STORE, 6'd16);
    send_request(FUNC_STORE, 6'd32);
    send_request(FUNC_STORE, 6'd62);
    send_request(FUNC_STORE, 6'd21);
    send_request(FUNC_STORE, 6'd42);
    send_request(FUNC_STORE, 6'd10);
    send_request(FUNC_STORE, 6'd63);
    send_request(FUNC_STORE, 6'd48);
    send_request(FUNC_STORE, 6'd12);
    send_request(FUNC_STORE, 6'd7);
    send_request(FUNC_STORE, 6'd0);
    move_car(6'd0);
    send_request(FUNC_EXECUTE, 6'd0);      // full list, every entry served
    move_car(6'd63);
    send_request(FUNC_EXECUTE, 6'd63);
    counted = 24;

    // random phases: mostly scans against a fresh car position, with
    // stores on the full list sprinkled in as noise
    while (counted < ITEM_TARGET) begin
      if (counted >= QUIET_FROM) no_idle = 1'b1;
      case (phase)
        0:       car = 6'd63;
        1:       car = 6'd0;
        3:       car = 6'd0;     // every entry lies above, so the walk must stall
        default: car = $urandom_range(0, 1) ?
                       sb.request_list[$urandom_range(0, sb.list_len - 1)] :
                       floor_t'($urandom_range(0, 63));
      endcase
      move_car(car);
      if (phase == 3) hold_off_req = 1'b1;
      n = $urandom_range(10, 30);
      repeat (n) begin
        if ($urandom_range(0, 6) == 0) begin
          send_request(FUNC_STORE, floor_t'($urandom_range(0, 63)));
        end else begin
          send_request(FUNC_EXECUTE, floor_t'($urandom_range(0, 63)));
        end
        counted++;
      end
      phase++;
    end

    settle_block();
    $display("%0d items accepted: %0d scans, %0d stores (%0d dropped on a full list)",
             sb.scans + sb.stores, sb.scans, sb.stores, sb.dropped);
    $display("%0d served floors checked over %0d car positions",
             sb.stops_checked, positions);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
